// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL. Every macro samples on clk_i and is
// disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("implication check failed");

// The consequent must hold in the cycle after the antecedent.
`define PPU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/ppu_pkg.sv =====
// ----------------------------------------------------------------------------
// Particle update package
// Widths, codes and saturation helpers shared by the particle update RTL.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppu_pkg;

  localparam int unsigned MaxDims      = 64;
  localparam int unsigned MaxParticles = 256;
  localparam int unsigned DimW         = 6;
  localparam int unsigned ValW         = 32;
  localparam int unsigned GainW        = 16;
  localparam int unsigned CountW       = 9;
  localparam int unsigned DimCountW    = 7;
  localparam int unsigned AccW         = 48;
  localparam int unsigned MulAW        = 17;
  localparam int unsigned MulBW        = 33;
  localparam int unsigned ProdW        = MulAW + MulBW;
  localparam int unsigned DivSteps     = AccW;
  localparam int unsigned DivCntW      = $clog2(DivSteps);

  typedef enum logic [2:0] {
    FUNC_LOAD_BOUNDS = 3'd0,
    FUNC_LOAD_STATE  = 3'd1,
    FUNC_BASIC       = 3'd2,
    FUNC_RESTART     = 3'd3,
    FUNC_FIPS        = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    CFG_INERTIA   = 3'd0,
    CFG_COGNITIVE = 3'd1,
    CFG_SOCIAL    = 3'd2,
    CFG_PARTICLES = 3'd3,
    CFG_DIMS      = 3'd4
  } cfg_idx_e;

  // Saturate a 49-bit signed sum to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    logic signed [31:0] r;
    if (v[48:31] == {18{v[48]}}) begin
      r = v[31:0];
    end else begin
      r = v[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

  // Saturate a 49-bit signed sum to 48 bits.
  function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
    logic signed [47:0] r;
    if (v[48] == v[47]) begin
      r = v[47:0];
    end else begin
      r = v[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ppu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppu_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ppu_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 17 x 33 bit multiplier with a registered product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppu_mul (
  input  wire logic                              clk_i,
  input  wire logic                              en_i,
  input  wire logic signed [ppu_pkg::MulAW-1:0]  a_i,
  input  wire logic signed [ppu_pkg::MulBW-1:0]  b_i,
  output logic      signed [ppu_pkg::ProdW-1:0]  prod_o
);

  logic signed [ppu_pkg::ProdW-1:0] prod_d;

  assign prod_d = ppu_pkg::ProdW'(a_i) * ppu_pkg::ProdW'(b_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o <= prod_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ppu_div.sv =====
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division of a signed 48-bit value by a 9-bit unsigned divisor,
// one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppu_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [ppu_pkg::AccW-1:0]     dividend_i,
  input  wire logic        [ppu_pkg::CountW-1:0]   divisor_i,
  output logic                                     done_o,
  output logic signed      [ppu_pkg::AccW-1:0]     quotient_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [ppu_pkg::DivCntW-1:0]      cnt_q, cnt_d;
  logic [ppu_pkg::AccW-1:0]         mag_q, mag_d;
  logic [ppu_pkg::CountW-1:0]       rem_q, rem_d;
  logic [ppu_pkg::CountW-1:0]       div_q, div_d;
  logic                             neg_q, neg_d;
  logic [ppu_pkg::CountW:0]         rem_sh;
  logic                             ge;

  assign rem_sh = {rem_q, mag_q[ppu_pkg::AccW-1]};
  assign ge     = rem_sh >= {1'b0, div_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mag_d  = mag_q;
    rem_d  = rem_q;
    div_d  = div_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = divisor_i;
      neg_d  = dividend_i[ppu_pkg::AccW-1];
      mag_d  = dividend_i[ppu_pkg::AccW-1] ? -dividend_i : dividend_i;
    end else if (busy_q) begin
      rem_d = ge ? ppu_pkg::CountW'(rem_sh - {1'b0, div_q}) : rem_sh[ppu_pkg::CountW-1:0];
      mag_d = {mag_q[ppu_pkg::AccW-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == ppu_pkg::DivCntW'(ppu_pkg::DivSteps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    rem_q <= rem_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -mag_q : mag_q;

endmodule

`default_nettype wire

// ===== rtl/pso_particle_update_unit.sv =====
// ----------------------------------------------------------------------------
// Particle swarm update unit
// Per-dimension velocity and position update for one particle, built around
// one shared multiplier and an iterative divider under a small sequencer.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake                 Payload
//   -------   -----------------------   --------------------------------------
//   cfg       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//   in        in_valid_i / in_stall_o   func, dim, value_a..d, rand1/2, last
//   out       out_valid_o / out_stall_i out_dim, new_position, new_velocity
//
// A load item or an ignored item never stalls the input. A FIPS term
// without last stalls the input through the multiply and sum states.
// Basic and restart updates pass through the multiply, sum and both
// clamp states, load the result register in the output state and then
// take the next item; a final FIPS term also waits in the divide state
// for the divider's 48 quotient bits and its done flag. The five products
// of an update are issued one per cycle on the single shared multiplier.
// Reset clears the configuration registers to their defaults, the sequencer
// and the FIPS accumulator; the stores hold garbage until loaded.
// A stalled result stays in the output register while the next item is taken;
// the sequencer only waits in its final state while that register holds a
// stalled result.
`timescale 1ns / 1ps
`default_nettype none

module pso_particle_update_unit (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // Configuration write channel
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [2:0]                           cfg_index_i,
  input  wire logic [ppu_pkg::GainW-1:0]            cfg_data_i,
  // Input channel
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [2:0]                           func_i,
  input  wire logic [ppu_pkg::DimW-1:0]             dim_i,
  input  wire logic signed [ppu_pkg::ValW-1:0]      value_a_i,
  input  wire logic signed [ppu_pkg::ValW-1:0]      value_b_i,
  input  wire logic signed [ppu_pkg::ValW-1:0]      value_c_i,
  input  wire logic signed [ppu_pkg::ValW-1:0]      value_d_i,
  input  wire logic [ppu_pkg::GainW-1:0]            rand1_i,
  input  wire logic [ppu_pkg::GainW-1:0]            rand2_i,
  input  wire logic                                 last_i,
  // Output channel
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic [ppu_pkg::DimW-1:0]                  out_dim_o,
  output logic signed [ppu_pkg::ValW-1:0]           new_position_o,
  output logic signed [ppu_pkg::ValW-1:0]           new_velocity_o
);

  `include "assert_macros.svh"

  // One-hot sequencer states.
  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_MUL     = 8'b0000_0010,
    ST_SUM     = 8'b0000_0100,
    ST_DIV     = 8'b0000_1000,
    ST_CLAMP_V = 8'b0001_0000,
    ST_CLAMP_P = 8'b0010_0000,
    ST_OUT     = 8'b0100_0000,
    ST_SPARE   = 8'b1000_0000
  } state_e;

  localparam logic [2:0] LastStep = 3'd5;

  state_e state_q, state_d;

  // Configuration registers.
  logic [ppu_pkg::GainW-1:0]     inertia_q, cognitive_q, social_q;
  logic [ppu_pkg::CountW-1:0]    particles_q;
  logic [ppu_pkg::DimCountW-1:0] dims_q;

  // Latched item.
  logic [ppu_pkg::DimW-1:0]        dim_q;
  logic signed [ppu_pkg::ValW-1:0] a_q, b_q, c_q;
  logic [ppu_pkg::GainW-1:0]       r1_q, r2_q;
  logic                            last_q, restart_q, fips_q;

  // Working registers.
  logic [2:0]                      step_q;
  logic [ppu_pkg::GainW-1:0]       gr1_q, gr2_q;
  logic signed [35:0]              inert_q;
  logic signed [37:0]              t1_q, t2_q;
  logic signed [ppu_pkg::AccW-1:0] acc_q;
  logic signed [ppu_pkg::ValW-1:0] nv_q, vcl_q, pos_q;

  // Output register.
  logic                            out_valid_q;
  logic [ppu_pkg::DimW-1:0]        out_dim_q;
  logic signed [ppu_pkg::ValW-1:0] out_pos_q, out_vel_q;

  logic in_xfer, out_xfer, out_free, out_load, dim_ok;
  logic ld_bounds, ld_state, start_upd;

  // Store read data.
  logic [ppu_pkg::ValW-1:0] x_raw, v_raw, pb_raw, pmin_raw, pmax_raw, vmin_raw, vmax_raw;
  logic signed [ppu_pkg::ValW-1:0] x_rd, v_rd, pb_rd, pmin_rd, pmax_rd, vmin_rd, vmax_rd;

  // Multiplier and divider.
  logic                                mul_en;
  logic signed [ppu_pkg::MulAW-1:0]    mul_a;
  logic signed [ppu_pkg::MulBW-1:0]    mul_b;
  logic signed [ppu_pkg::ProdW-1:0]    prod;
  logic                                div_start, div_done;
  logic signed [ppu_pkg::AccW-1:0]     quotient;
  logic [ppu_pkg::CountW-1:0]          divisor;

  logic signed [ppu_pkg::ValW-1:0]  base_x, vin;
  logic signed [ppu_pkg::MulBW-1:0] diff1, diff2;
  logic signed [ppu_pkg::AccW-1:0]  acc_sum;
  logic signed [48:0]               sum3, sum_div;
  logic signed [ppu_pkg::ValW-1:0]  v_lo;
  logic signed [ppu_pkg::ValW:0]    pos_base, p_lo;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_xfer    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_load    = (state_q == ST_OUT) && out_free;

  assign dim_ok    = {1'b0, dim_i} < dims_q;
  assign ld_bounds = in_xfer && dim_ok && (func_i == ppu_pkg::FUNC_LOAD_BOUNDS);
  assign ld_state  = in_xfer && dim_ok && (func_i == ppu_pkg::FUNC_LOAD_STATE);
  assign start_upd = in_xfer && dim_ok &&
                     ((func_i == ppu_pkg::FUNC_BASIC) || (func_i == ppu_pkg::FUNC_RESTART) ||
                      (func_i == ppu_pkg::FUNC_FIPS));

  // ---------------------------------------------------------------------------
  // Configuration writes. The channel is always ready; unknown indexes are
  // dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inertia_q   <= 16'd4096;
      cognitive_q <= 16'd4096;
      social_q    <= 16'd4096;
      particles_q <= 9'd1;
      dims_q      <= 7'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ppu_pkg::CFG_INERTIA:   inertia_q   <= cfg_data_i;
        ppu_pkg::CFG_COGNITIVE: cognitive_q <= cfg_data_i;
        ppu_pkg::CFG_SOCIAL:    social_q    <= cfg_data_i;
        ppu_pkg::CFG_PARTICLES: particles_q <= cfg_data_i[ppu_pkg::CountW-1:0];
        ppu_pkg::CFG_DIMS:      dims_q      <= cfg_data_i[ppu_pkg::DimCountW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stores. Every store is read at the transferred dimension in the transfer
  // cycle, so the data is ready by the time the sequencer needs it and stays
  // put for the rest of the update.
  // ---------------------------------------------------------------------------
  ppu_ram #(.Width(ppu_pkg::ValW), .Depth(ppu_pkg::MaxDims)) u_pos_ram (
    .clk_i, .we_i(ld_state || out_load), .waddr_i(out_load ? dim_q : dim_i),
    .wdata_i(out_load ? pos_q : value_a_i), .re_i(in_xfer), .raddr_i(dim_i),
    .rdata_o(x_raw)
  );
  ppu_ram #(.Width(ppu_pkg::ValW), .Depth(ppu_pkg::MaxDims)) u_vel_ram (
    .clk_i, .we_i(ld_state || out_load), .waddr_i(out_load ? dim_q : dim_i),
    .wdata_i(out_load ? vcl_q : value_b_i), .re_i(in_xfer), .raddr_i(dim_i),
    .rdata_o(v_raw)
  );
  ppu_ram #(.Width(ppu_pkg::ValW), .Depth(ppu_pkg::MaxDims)) u_pbest_ram (
    .clk_i, .we_i(ld_state), .waddr_i(dim_i), .wdata_i(value_c_i),
    .re_i(in_xfer), .raddr_i(dim_i), .rdata_o(pb_raw)
  );
  ppu_ram #(.Width(ppu_pkg::ValW), .Depth(ppu_pkg::MaxDims)) u_pmin_ram (
    .clk_i, .we_i(ld_bounds), .waddr_i(dim_i), .wdata_i(value_a_i),
    .re_i(in_xfer), .raddr_i(dim_i), .rdata_o(pmin_raw)
  );
  ppu_ram #(.Width(ppu_pkg::ValW), .Depth(ppu_pkg::MaxDims)) u_pmax_ram (
    .clk_i, .we_i(ld_bounds), .waddr_i(dim_i), .wdata_i(value_b_i),
    .re_i(in_xfer), .raddr_i(dim_i), .rdata_o(pmax_raw)
  );
  ppu_ram #(.Width(ppu_pkg::ValW), .Depth(ppu_pkg::MaxDims)) u_vmin_ram (
    .clk_i, .we_i(ld_bounds), .waddr_i(dim_i), .wdata_i(value_c_i),
    .re_i(in_xfer), .raddr_i(dim_i), .rdata_o(vmin_raw)
  );
  ppu_ram #(.Width(ppu_pkg::ValW), .Depth(ppu_pkg::MaxDims)) u_vmax_ram (
    .clk_i, .we_i(ld_bounds), .waddr_i(dim_i), .wdata_i(value_d_i),
    .re_i(in_xfer), .raddr_i(dim_i), .rdata_o(vmax_raw)
  );

  assign x_rd    = $signed(x_raw);
  assign v_rd    = $signed(v_raw);
  assign pb_rd   = $signed(pb_raw);
  assign pmin_rd = $signed(pmin_raw);
  assign pmax_rd = $signed(pmax_raw);
  assign vmin_rd = $signed(vmin_raw);
  assign vmax_rd = $signed(vmax_raw);

  // ---------------------------------------------------------------------------
  // Multiplier schedule. Step 0 and 1 form the two gain-times-random factors,
  // step 2 the inertia product, steps 3 and 4 the two pulls. Each product is
  // collected one step after it is issued. A restart measures from the given
  // start position, and a FIPS term pulls toward the neighbour best only.
  // ---------------------------------------------------------------------------
  assign base_x = restart_q ? b_q : x_rd;
  assign vin    = restart_q ? c_q : v_rd;
  assign diff1  = fips_q ? ({a_q[31], a_q} - {base_x[31], base_x})
                         : ({pb_rd[31], pb_rd} - {base_x[31], base_x});
  assign diff2  = {a_q[31], a_q} - {base_x[31], base_x};

  assign mul_en = (state_q == ST_MUL) && (step_q != LastStep);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (step_q)
      3'd0: begin
        mul_a = {1'b0, cognitive_q};
        mul_b = {17'b0, r1_q};
      end
      3'd1: begin
        mul_a = {1'b0, social_q};
        mul_b = {17'b0, r2_q};
      end
      3'd2: begin
        mul_a = {1'b0, inertia_q};
        mul_b = {vin[31], vin};
      end
      3'd3: begin
        mul_a = {1'b0, gr1_q};
        mul_b = diff1;
      end
      3'd4: begin
        mul_a = {1'b0, gr2_q};
        mul_b = diff2;
      end
      default: ;
    endcase
  end

  ppu_mul u_mul (
    .clk_i,
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .prod_o(prod)
  );

  // ---------------------------------------------------------------------------
  // Sums, FIPS divisor and clamps.
  // ---------------------------------------------------------------------------
  assign sum3 = {{13{inert_q[35]}}, inert_q} + {{11{t1_q[37]}}, t1_q} +
                {{11{t2_q[37]}}, t2_q};
  assign acc_sum = ppu_pkg::sat48({acc_q[47], acc_q} + {{11{t1_q[37]}}, t1_q});
  assign sum_div = {{13{inert_q[35]}}, inert_q} + {quotient[47], quotient};

  // A particle count of zero divides by one, and counts above the maximum
  // saturate to it.
  always_comb begin
    if (particles_q == '0) begin
      divisor = ppu_pkg::CountW'(1);
    end else if (particles_q > ppu_pkg::CountW'(ppu_pkg::MaxParticles)) begin
      divisor = ppu_pkg::CountW'(ppu_pkg::MaxParticles);
    end else begin
      divisor = particles_q;
    end
  end

  assign div_start = (state_q == ST_SUM) && fips_q && last_q;

  ppu_div u_div (
    .clk_i,
    .rst_ni,
    .start_i   (div_start),
    .dividend_i(acc_sum),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  // Lower bound first, then upper bound, so crossed bounds give the upper one.
  assign v_lo     = (nv_q < vmin_rd) ? vmin_rd : nv_q;
  assign pos_base = restart_q ? ({b_q[31], b_q} + {nv_q[31], nv_q})
                              : ({x_rd[31], x_rd} + {vcl_q[31], vcl_q});
  assign p_lo     = (pos_base < $signed({pmin_rd[31], pmin_rd}))
                    ? $signed({pmin_rd[31], pmin_rd}) : pos_base;

  // ---------------------------------------------------------------------------
  // Sequencer.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (start_upd) state_d = ST_MUL;
      ST_MUL:     if (step_q == LastStep) state_d = ST_SUM;
      ST_SUM: begin
        if (!fips_q) begin
          state_d = ST_CLAMP_V;
        end else if (last_q) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DIV:     if (div_done) state_d = ST_CLAMP_V;
      ST_CLAMP_V: state_d = ST_CLAMP_P;
      ST_CLAMP_P: state_d = ST_OUT;
      ST_OUT:     if (out_free) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start_upd) begin
        step_q <= '0;
      end else if (state_q == ST_MUL) begin
        step_q <= step_q + 1'b1;
      end
      if ((state_q == ST_SUM) && fips_q) begin
        acc_q <= acc_sum;
      end else if ((state_q == ST_DIV) && div_done) begin
        acc_q <= '0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_upd) begin
      dim_q     <= dim_i;
      a_q       <= value_a_i;
      b_q       <= value_b_i;
      c_q       <= value_c_i;
      r1_q      <= rand1_i;
      r2_q      <= rand2_i;
      last_q    <= last_i;
      restart_q <= (func_i == ppu_pkg::FUNC_RESTART);
      fips_q    <= (func_i == ppu_pkg::FUNC_FIPS);
    end
    if (state_q == ST_MUL) begin
      unique case (step_q)
        3'd1:    gr1_q   <= prod[31:16];
        3'd2:    gr2_q   <= prod[31:16];
        3'd3:    inert_q <= prod[47:12];
        3'd4:    t1_q    <= prod[49:12];
        3'd5:    t2_q    <= prod[49:12];
        default: ;
      endcase
    end
    if ((state_q == ST_SUM) && !fips_q) begin
      nv_q <= ppu_pkg::sat32(sum3);
    end else if ((state_q == ST_DIV) && div_done) begin
      nv_q <= ppu_pkg::sat32(sum_div);
    end
    if (state_q == ST_CLAMP_V) begin
      vcl_q <= (v_lo > vmax_rd) ? vmax_rd : v_lo;
    end
    if (state_q == ST_CLAMP_P) begin
      pos_q <= (p_lo > $signed({pmax_rd[31], pmax_rd})) ? pmax_rd : p_lo[31:0];
    end
    if (out_load) begin
      out_dim_q <= dim_q;
      out_pos_q <= pos_q;
      out_vel_q <= vcl_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_dim_o      = out_dim_q;
  assign new_position_o = out_pos_q;
  assign new_velocity_o = out_vel_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `PPU_ASSERT_IMPL(a_div_done_in_div, div_done, state_q == ST_DIV)
  `PPU_ASSERT_IMPL(a_acc_clear_after_fips, (state_q == ST_CLAMP_V) && fips_q, acc_q == '0)
  `PPU_ASSERT_NEXT(a_result_from_out_state, !out_valid_q && (state_q != ST_OUT), !out_valid_q)

endmodule

`default_nettype wire
